// ----- hdl/olst_pkg.sv -----
package olst_pkg;

  // Default sizes of the list
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int VALUE_BITS_DEF  = 32;

  // Fixed widths of the item fields on the ports
  localparam int FUNC_W     = 2;
  localparam int ID_PORT_W  = 8;
  localparam int VAL_PORT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int POS_PORT_W = 4;
  localparam int CNT_PORT_W = 5;
  localparam int CUR_PORT_W = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_SORTED = 2'd0;
  localparam logic [FUNC_W-1:0] FN_AFTER  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP      = 2'd3;

  // Shift command broadcast to every cell
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_OPEN,
    SH_CLOSE
  } olst_shift_e;

  // Compare flags that one cell reports
  typedef struct packed {
    logic match;
    logic first;
    logic found;
  } olst_flag_t;

endpackage

// ----- hdl/ordered_task_list_core.sv -----
// Ordered task list: up to MAX_ENTRIES (id, value) entries held in a row of cells, lowest value
// first, plus a cursor. Each item has a compare cycle in which every cell checks
// its id and value against the item at once, then a shift cycle in which the cells open or close
// a gap by moving one place toward their neighbor. The result sits in an output register, and a
// new item is taken on the edge that ends the shift cycle when that register is free. After reset
// the list is empty at once; there is no clearing pass.
module ordered_task_list_core
  import olst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [FUNC_W-1:0]            func_i,
  input  logic [ID_PORT_W-1:0]         item_id_i,
  input  logic [VAL_PORT_W-1:0]        item_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic [POS_PORT_W-1:0]        position_o,
  output logic [CNT_PORT_W-1:0]        item_count_o,
  output logic signed [CUR_PORT_W-1:0] cursor_pos_o,
  output logic [ID_PORT_W-1:0]         head_id_o,
  output logic                         head_valid_o
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CUR_W = IDX_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SHIFT
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [CUR_W-1:0]  cursor_q, cursor_d;
  logic                     out_valid_q;

  logic [FUNC_W-1:0]        func_q;
  logic [ID_BITS-1:0]       key_id_q;
  logic [VALUE_BITS-1:0]    key_val_q;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic [IDX_W-1:0]         pos_q, pos_d;

  logic [STATUS_W-1:0]      out_status_q;
  logic [POS_PORT_W-1:0]    out_pos_q;
  logic [CNT_PORT_W-1:0]    out_count_q;
  logic signed [CUR_PORT_W-1:0] out_cursor_q;
  logic [ID_PORT_W-1:0]     out_head_id_q;
  logic                     out_head_vld_q;

  logic                     out_free, finish, in_accept;
  logic [ID_BITS-1:0]       head_d;
  olst_shift_e              cell_op;

  logic [MAX_ENTRIES-1:0]   occupied;
  olst_flag_t               flags   [MAX_ENTRIES];
  logic [ID_BITS-1:0]       cell_id [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]    cell_val[MAX_ENTRIES];

  logic                     match_any, first_any;
  logic [IDX_W-1:0]         match_idx, first_idx;

  // Handshake: take an item when idle or as the shift cycle retires
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_SHIFT) && out_free;
  assign in_stall_o = !((state_q == S_IDLE) || finish);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Row of cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ID_BITS-1:0]    left_id, right_id;
    logic [VALUE_BITS-1:0] left_val, right_val;
    logic                  found_in;

    assign occupied[g] = CNT_W'(g) < count_q;

    if (g == 0) begin : g_first
      assign left_id  = key_id_q;
      assign left_val = key_val_q;
      assign found_in = 1'b0;
    end else begin : g_mid
      assign left_id  = cell_id[g-1];
      assign left_val = cell_val[g-1];
      assign found_in = flags[g-1].found;
    end

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_id  = cell_id[g];
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_id  = cell_id[g+1];
      assign right_val = cell_val[g+1];
    end

    olst_cell #(
      .ID_W  (ID_BITS),
      .VAL_W (VALUE_BITS),
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .occupied_i  (occupied[g]),
      .key_id_i    (key_id_q),
      .key_val_i   (key_val_q),
      .pos_i       (pos_q),
      .left_id_i   (left_id),
      .left_val_i  (left_val),
      .right_id_i  (right_id),
      .right_val_i (right_val),
      .found_i     (found_in),
      .flag_o      (flags[g]),
      .id_o        (cell_id[g]),
      .val_o       (cell_val[g])
    );
  end

  // Encode the one-hot match and first-greater flags
  always_comb begin
    match_any = 1'b0;
    first_any = 1'b0;
    match_idx = '0;
    first_idx = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (flags[k].match) begin
        match_any = 1'b1;
        match_idx = match_idx | IDX_W'(k);
      end
      if (flags[k].first) begin
        first_any = 1'b1;
        first_idx = first_idx | IDX_W'(k);
      end
    end
  end

  // Decide status and position in the compare cycle
  always_comb begin
    status_d = ST_DONE;
    pos_d    = '0;
    unique case (func_q)
      FN_SORTED, FN_AFTER: begin
        if (count_q == CNT_W'(MAX_ENTRIES)) begin
          status_d = ST_FULL;
        end else if (match_any) begin
          status_d = ST_DUP;
        end else if (func_q == FN_SORTED) begin
          pos_d = first_any ? first_idx : count_q[IDX_W-1:0];
        end else begin
          pos_d = IDX_W'(cursor_q + CUR_W'(1));
        end
      end
      FN_REMOVE: begin
        if (match_any) begin
          pos_d = match_idx;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      FN_CLEAR: begin
        status_d = ST_DONE;
      end
    endcase
  end

  // Work out count, cursor, head and the cell command for the shift cycle
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    head_d   = cell_id[0];
    cell_op  = SH_HOLD;
    if (status_q == ST_DONE) begin
      priority if (func_q == FN_SORTED || func_q == FN_AFTER) begin
        count_d = count_q + CNT_W'(1);
        if (pos_q == '0) begin
          head_d = key_id_q;
        end
        if (func_q == FN_AFTER) begin
          cursor_d = $signed({1'b0, pos_q});
        end else if (cursor_q >= $signed({1'b0, pos_q})) begin
          cursor_d = cursor_q + CUR_W'(1);
        end
        cell_op = finish ? SH_OPEN : SH_HOLD;
      end else if (func_q == FN_REMOVE) begin
        count_d = count_q - CNT_W'(1);
        if (pos_q == '0) begin
          head_d = cell_id[1];
        end
        if (cursor_q >= $signed({1'b0, pos_q})) begin
          cursor_d = cursor_q - CUR_W'(1);
        end
        cell_op = finish ? SH_CLOSE : SH_HOLD;
      end else begin
        count_d  = '0;
        cursor_d = '1;
      end
    end
  end

  // Hold state, list occupancy, cursor and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          if (finish) begin
            state_q <= in_accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (finish) begin
        count_q     <= count_d;
        cursor_q    <= cursor_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch the item, the decision and the result fields
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q    <= func_i;
      key_id_q  <= ID_BITS'(item_id_i);
      key_val_q <= VALUE_BITS'(item_value_i);
    end
    if (state_q == S_CMP) begin
      status_q <= status_d;
      pos_q    <= pos_d;
    end
    if (finish) begin
      out_status_q   <= status_q;
      out_pos_q      <= POS_PORT_W'(pos_q);
      out_count_q    <= CNT_PORT_W'(count_d);
      out_cursor_q   <= CUR_PORT_W'(cursor_d);
      out_head_id_q  <= (count_d == '0) ? '0 : ID_PORT_W'(head_d);
      out_head_vld_q <= (count_d != '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign position_o   = out_pos_q;
  assign item_count_o = out_count_q;
  assign cursor_pos_o = out_cursor_q;
  assign head_id_o    = out_head_id_q;
  assign head_valid_o = out_head_vld_q;

endmodule

// ----- hdl/olst_cell.sv -----
module olst_cell
  import olst_pkg::*;
#(
  parameter int ID_W  = ID_BITS_DEF,
  parameter int VAL_W = VALUE_BITS_DEF,
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic              clk_i,
  input  olst_shift_e       op_i,
  input  logic              occupied_i,
  input  logic [ID_W-1:0]   key_id_i,
  input  logic [VAL_W-1:0]  key_val_i,
  input  logic [IDX_W-1:0]  pos_i,
  input  logic [ID_W-1:0]   left_id_i,
  input  logic [VAL_W-1:0]  left_val_i,
  input  logic [ID_W-1:0]   right_id_i,
  input  logic [VAL_W-1:0]  right_val_i,
  input  logic              found_i,
  output olst_flag_t        flag_o,
  output logic [ID_W-1:0]   id_o,
  output logic [VAL_W-1:0]  val_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ID_W-1:0]  id_q, id_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             gt;

  // Compare against the broadcast key; pass the first-greater search on
  assign gt             = occupied_i && (val_q > key_val_i);
  assign flag_o.match   = occupied_i && (id_q == key_id_i);
  assign flag_o.first   = gt && !found_i;
  assign flag_o.found   = found_i || gt;

  // Open a gap toward the tail or close one from the tail
  always_comb begin
    id_d  = id_q;
    val_d = val_q;
    unique case (op_i)
      SH_OPEN: begin
        if (MY_IDX == pos_i) begin
          id_d  = key_id_i;
          val_d = key_val_i;
        end else if (MY_IDX > pos_i) begin
          id_d  = left_id_i;
          val_d = left_val_i;
        end
      end
      SH_CLOSE: begin
        if (MY_IDX >= pos_i) begin
          id_d  = right_id_i;
          val_d = right_val_i;
        end
      end
      default: begin
        id_d  = id_q;
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    val_q <= val_d;
  end

  assign id_o  = id_q;
  assign val_o = val_q;

endmodule

// ----- hdl/olst_checker.sv -----
module olst_checker
  import olst_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [FUNC_W-1:0]            func_i,
  input logic [ID_PORT_W-1:0]         item_id_i,
  input logic [VAL_PORT_W-1:0]        item_value_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [STATUS_W-1:0]          status_o,
  input logic [POS_PORT_W-1:0]        position_o,
  input logic [CNT_PORT_W-1:0]        item_count_o,
  input logic signed [CUR_PORT_W-1:0] cursor_pos_o,
  input logic [ID_PORT_W-1:0]         head_id_o,
  input logic                         head_valid_o
);

  // Head flag follows the entry count
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head_valid_o == (item_count_o != '0)))
    else $error("head_valid does not match item_count");

  // An empty list leaves the cursor at the end marker
  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_count_o == '0) |-> (cursor_pos_o == '1))
    else $error("cursor not at end marker on empty list");

  // Cursor stays below the entry count
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(cursor_pos_o) < $signed({1'b0, item_count_o})))
    else $error("cursor beyond last entry");

  // Failed operations report position zero
  a_error_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DONE) |-> (position_o == '0))
    else $error("nonzero position on failed operation");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(position_o) && $stable(item_count_o) && $stable(cursor_pos_o) &&
      $stable(head_id_o) && $stable(head_valid_o)))
    else $error("stalled result changed");

endmodule

bind ordered_task_list_core olst_checker u_olst_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 100ps

import olst_pkg::*;

// One result item as the block reports it
typedef struct packed {
  logic [STATUS_W-1:0]   status;
  logic [POS_PORT_W-1:0] position;
  logic [CNT_PORT_W-1:0] item_count;
  logic [CUR_PORT_W-1:0] cursor_pos;
  logic [ID_PORT_W-1:0]  head_id;
  logic                  head_valid;
} olist_reply_t;

// Shadow copy of the task list: predicts each reply and checks what comes back
class olist_shadow;
  logic [ID_PORT_W-1:0]  ids  [MAX_ENTRIES_DEF];
  logic [VAL_PORT_W-1:0] vals [MAX_ENTRIES_DEF];
  int                    count;
  int                    cursor;
  olist_reply_t          replies_due[$];
  int                    errors;

  function new();
    count  = 0;
    cursor = -1;
    errors = 0;
  endfunction

  // Apply an accepted request to the shadow list and queue its reply
  function void take_request(logic [FUNC_W-1:0] fn, logic [ID_PORT_W-1:0] id,
                             logic [VAL_PORT_W-1:0] val);
    olist_reply_t r;
    int hit;
    int p;
    r = '0;
    r.status = ST_DONE;
    hit = -1;
    for (int k = 0; k < count; k++) begin
      if (hit < 0 && ids[k] == id) hit = k;
    end
    case (fn)
      FN_SORTED, FN_AFTER: begin
        if (count >= MAX_ENTRIES_DEF) begin
          r.status = ST_FULL;
        end else if (hit >= 0) begin
          r.status = ST_DUP;
        end else begin
          if (fn == FN_SORTED) begin
            // first entry with a larger value; ties keep arrival order
            p = 0;
            while (p < count && vals[p] <= val) p++;
            if (cursor >= p) cursor++;
          end else begin
            p = cursor + 1;
            cursor = p;
          end
          // open the gap at p
          for (int k = count; k > p; k--) begin
            ids[k]  = ids[k-1];
            vals[k] = vals[k-1];
          end
          ids[p]  = id;
          vals[p] = val;
          count++;
          r.position = p[POS_PORT_W-1:0];
        end
      end
      FN_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // close the gap and pull the cursor back when it sat at or after it
          for (int k = hit; k + 1 < count; k++) begin
            ids[k]  = ids[k+1];
            vals[k] = vals[k+1];
          end
          count--;
          if (cursor >= hit) cursor--;
          r.position = hit[POS_PORT_W-1:0];
        end
      end
      default: begin
        count  = 0;
        cursor = -1;
      end
    endcase
    r.item_count = count[CNT_PORT_W-1:0];
    r.cursor_pos = cursor[CUR_PORT_W-1:0];
    r.head_valid = (count > 0);
    r.head_id    = (count > 0) ? ids[0] : '0;
    replies_due.push_back(r);
  endfunction

  // Compare one accepted reply with the oldest prediction
  function void check_reply(olist_reply_t got);
    olist_reply_t want;
    if (replies_due.size() == 0) begin
      $error("reply with nothing expected: status %0d count %0d", got.status, got.item_count);
      errors++;
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      errors++;
    end
    if (got.item_count !== want.item_count) begin
      $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
      errors++;
    end
    if (got.cursor_pos !== want.cursor_pos) begin
      $error("cursor_pos: expected %0d, got %0d",
             $signed(want.cursor_pos), $signed(got.cursor_pos));
      errors++;
    end
    if (got.head_id !== want.head_id) begin
      $error("head_id: expected %0d, got %0d", want.head_id, got.head_id);
      errors++;
    end
    if (got.head_valid !== want.head_valid) begin
      $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
      errors++;
    end
  endfunction
endclass

module tb;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [FUNC_W-1:0]            func_i;
  logic [ID_PORT_W-1:0]         item_id_i;
  logic [VAL_PORT_W-1:0]        item_value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [STATUS_W-1:0]          status_o;
  logic [POS_PORT_W-1:0]        position_o;
  logic [CNT_PORT_W-1:0]        item_count_o;
  logic signed [CUR_PORT_W-1:0] cursor_pos_o;
  logic [ID_PORT_W-1:0]         head_id_o;
  logic                         head_valid_o;

  olist_shadow shadow;
  int          idle_pct;
  int          stall_pct;

  ordered_task_list_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .item_id_i    (item_id_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .item_count_o (item_count_o),
    .cursor_pos_o (cursor_pos_o),
    .head_id_o    (head_id_o),
    .head_valid_o (head_valid_o)
  );

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Take replies, stalling at random
  initial begin
    olist_reply_t got;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status     = status_o;
        got.position   = position_o;
        got.item_count = item_count_o;
        got.cursor_pos = cursor_pos_o;
        got.head_id    = head_id_o;
        got.head_valid = head_valid_o;
        shadow.check_reply(got);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [ID_PORT_W-1:0] id,
                           logic [VAL_PORT_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    item_id_i    <= id;
    item_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    shadow.take_request(fn, id, val);
  endtask

  // Hold off the sender until every reply is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (shadow.replies_due.size() != 0);
  endtask

  // Build one random request; grow_pct sets how often it inserts
  task automatic send_random(int grow_pct);
    logic [FUNC_W-1:0]     fn;
    logic [ID_PORT_W-1:0]  id;
    logic [VAL_PORT_W-1:0] val;
    int                    roll;
    roll = $urandom_range(99);
    if (roll < 3) fn = FN_CLEAR;
    else if (roll < 3 + grow_pct) fn = ($urandom_range(2) == 0) ? FN_AFTER : FN_SORTED;
    else fn = FN_REMOVE;
    // mostly known ids on remove, a few duplicates on insert
    if (shadow.count > 0 && $urandom_range(99) < ((fn == FN_REMOVE) ? 80 : 12))
      id = shadow.ids[$urandom_range(shadow.count - 1)];
    else
      id = ID_PORT_W'($urandom);
    case ($urandom_range(3))
      0:       val = $urandom;
      1:       val = $urandom_range(7);
      2:       val = $urandom_range(1) ? '1 : '0;
      default: val = $urandom_range(100);
    endcase
    send_item(fn, id, val);
  endtask

  initial begin
    int idle_set  [5] = '{0, 70, 0, 30, 0};
    int stall_set [5] = '{0, 0, 70, 30, 0};
    int grow_set  [3] = '{40, 60, 85};
    int grow_pct;
    shadow       = new();
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    func_i       <= FN_CLEAR;
    item_id_i    <= '0;
    item_value_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list cases, ties, duplicate, fill to full, cursor removal
    send_item(FN_REMOVE, 8'd5, 32'd0);
    send_item(FN_CLEAR, 8'd0, 32'd0);
    send_item(FN_AFTER, 8'h00, 32'hFFFF_FFFF);
    send_item(FN_SORTED, 8'hFF, 32'h0000_0000);
    send_item(FN_SORTED, 8'hFF, 32'd7);
    send_item(FN_AFTER, 8'h80, 32'd5);
    send_item(FN_SORTED, 8'h11, 32'd5);
    for (int k = 0; k < 12; k++) begin
      send_item((k % 3 == 0) ? FN_AFTER : FN_SORTED, ID_PORT_W'(8'hA0 + k),
                32'h1357_9BDF * k);
    end
    send_item(FN_SORTED, 8'h33, 32'd9);
    send_item(FN_AFTER, 8'h11, 32'd9);
    send_item(FN_REMOVE, shadow.ids[shadow.cursor], 32'd0);
    send_item(FN_REMOVE, shadow.ids[0], 32'd0);
    send_item(FN_REMOVE, 8'h7F, 32'd0);
    send_item(FN_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    send_item(FN_AFTER, 8'h42, 32'd1);
    send_item(FN_REMOVE, 8'h42, 32'd1);
    wait_drained();

    // Random: five phases of idle and stall rates, insert bias changing every 25 items
    grow_pct = 60;
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < 106; n++) begin
        if (n % 25 == 0) grow_pct = grow_set[$urandom_range(2)];
        send_random(grow_pct);
      end
      wait_drained();
    end

    // Let the pipeline settle, then report
    repeat (20) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.replies_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
